[rtl/fan_curve_interpolator_macros.svh]
// Assertion macros shared by the fan curve checker.
`ifndef FAN_CURVE_INTERPOLATOR_MACROS_SVH
`define FAN_CURVE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define FCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define FCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fci_pkg.sv]
// Shared constants, types and helper functions of the fan curve interpolator.
package fci_pkg;

  // Table size and derived index widths.
  localparam int MAX_POINTS = 32;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int TEMP_W   = 16;
  localparam int SPEED_W  = 12;
  localparam int DUTY_W   = 8;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = TEMP_W + SPEED_W;

  // Interpolation arithmetic widths.
  localparam int DT_W   = TEMP_W + 1;
  localparam int DS_W   = SPEED_W + 1;
  localparam int PROD_W = DT_W + DS_W;
  localparam int MAG_W  = TEMP_W + SPEED_W;
  localparam int DEN_W  = TEMP_W;

  // Duty conversion constants.
  localparam int FULL_SPEED = 1024;
  localparam int DUTY_MAX   = 255;
  localparam int FULL_W     = $clog2(FULL_SPEED) + 1;
  localparam int DPROD_W    = FULL_W + DUTY_W;

  // Action codes; any action with the query bit set is a query.
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam int                  ACT_QUERY_BIT = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_STORED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4,
    ST_NOSEG   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_FIRST,
    S_LAST,
    S_WALK,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_FINISH
  } state_e;

  // Table read address selection.
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_ONE,
    RD_NEXT
  } rd_sel_e;

  // Result register update selection.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_APPLY,
    RES_EMPTY,
    RES_RDATA,
    RES_PREV,
    RES_NOSEG,
    RES_DIV
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;
    rd_sel_e  rd_sel;
    logic     load_prev;
    logic     idx_init;
    logic     idx_inc;
    logic     seg_load;
    logic     mul_en;
    logic     div_start;
    res_sel_e res_sel;
    logic     out_load;
  } fci_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic cnt_zero;
    logic le_first;
    logic ge_last;
    logic in_seg;
    logic zero_width;
    logic walk_end;
    logic div_done;
    logic out_free;
  } fci_sts_t;

  // Clamp the speed to full scale and scale it to an 8-bit duty.
  function automatic logic [DUTY_W-1:0] duty_of(input logic [SPEED_W-1:0] level);
    logic [FULL_W-1:0]  clamped;
    logic [DPROD_W-1:0] prod;
    clamped = (level > SPEED_W'(FULL_SPEED)) ? FULL_W'(FULL_SPEED) : FULL_W'(level);
    prod    = DPROD_W'(clamped) * DPROD_W'(DUTY_MAX);
    // Dividing by full scale drops the low bits of the product.
    return prod[FULL_W-1 +: DUTY_W];
  endfunction

endpackage

[rtl/fci_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fci_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module fci_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fci_pkg::MAG_W-1:0]   dividend_i,
  input  logic [fci_pkg::DEN_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [fci_pkg::MAG_W-1:0]   quotient_o
);

  localparam int STEP_W = $clog2(fci_pkg::MAG_W + 1);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [STEP_W-1:0]           step_q, step_d;
  logic [fci_pkg::DEN_W-1:0]   rem_q, rem_d;
  logic [fci_pkg::DEN_W-1:0]   dsr_q, dsr_d;
  logic [fci_pkg::MAG_W-1:0]   quo_q, quo_d;
  logic [fci_pkg::DEN_W:0]     rem_shift;
  logic [fci_pkg::DEN_W:0]     rem_sub;
  logic                        fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_shift = {rem_q, quo_q[fci_pkg::MAG_W-1]};
    rem_sub   = rem_shift - {1'b0, dsr_q};
    fits      = (rem_shift >= {1'b0, dsr_q});
  end

  // Step sequencing and operand registers.
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = STEP_W'(fci_pkg::MAG_W);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (run_q) begin
      rem_d  = fits ? rem_sub[fci_pkg::DEN_W-1:0] : rem_shift[fci_pkg::DEN_W-1:0];
      quo_d  = {quo_q[fci_pkg::MAG_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/fci_dp.sv]
// Datapath: breakpoint table, segment registers, multiplier, divider and result word.
module fci_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fci_pkg::fci_cmd_t              cmd_i,
  output fci_pkg::fci_sts_t              sts_o,
  input  logic [fci_pkg::ACTION_W-1:0]   action_i,
  input  logic signed [fci_pkg::TEMP_W-1:0] temperature_i,
  input  logic [fci_pkg::SPEED_W-1:0]    speed_point_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [fci_pkg::DUTY_W-1:0]     duty_o,
  output logic [fci_pkg::SPEED_W-1:0]    speed_level_o,
  output logic [fci_pkg::STATUS_W-1:0]   status_o
);

  // Latched input word.
  logic [fci_pkg::ACTION_W-1:0]        act_q;
  logic signed [fci_pkg::TEMP_W-1:0]   t_q;
  logic [fci_pkg::SPEED_W-1:0]         sp_q;

  // Table control.
  logic [fci_pkg::CNT_W-1:0]           cnt_q, cnt_d;
  logic [fci_pkg::IDX_W-1:0]           idx_q;
  logic [fci_pkg::IDX_W-1:0]           raddr;
  logic                                we;
  logic [fci_pkg::ENTRY_W-1:0]         rdata;
  logic signed [fci_pkg::TEMP_W-1:0]   cur_t;
  logic [fci_pkg::SPEED_W-1:0]         cur_s;
  logic                                cnt_full;
  logic [fci_pkg::CNT_W-1:0]           cnt_last;

  // Segment and arithmetic registers.
  logic signed [fci_pkg::TEMP_W-1:0]   prev_t_q;
  logic [fci_pkg::SPEED_W-1:0]         prev_s_q;
  logic signed [fci_pkg::DT_W-1:0]     dt_q;
  logic signed [fci_pkg::DS_W-1:0]     ds_q;
  logic [fci_pkg::DEN_W-1:0]           den_q;
  logic signed [fci_pkg::PROD_W-1:0]   prod_q;
  logic signed [fci_pkg::DT_W-1:0]     den_full;
  logic [fci_pkg::PROD_W-1:0]          prod_abs;
  logic                                prod_neg;
  logic                                div_done;
  logic [fci_pkg::MAG_W-1:0]           quotient;
  logic [fci_pkg::DS_W-1:0]            div_level;

  // Result and output registers.
  logic [fci_pkg::SPEED_W-1:0]         level_q, level_d;
  fci_pkg::status_e                    res_st_q, res_st_d;
  logic                                out_valid_q, out_valid_d;
  logic [fci_pkg::DUTY_W-1:0]          duty_q;
  logic [fci_pkg::SPEED_W-1:0]         out_level_q;
  fci_pkg::status_e                    out_st_q;

  // Breakpoint table: temperature in the upper bits, speed in the lower.
  fci_ram #(
    .WIDTH (fci_pkg::ENTRY_W),
    .DEPTH (fci_pkg::MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[fci_pkg::IDX_W-1:0]),
    .wdata_i ({t_q, sp_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cur_t    = rdata[fci_pkg::ENTRY_W-1 -: fci_pkg::TEMP_W];
  assign cur_s    = rdata[fci_pkg::SPEED_W-1:0];
  assign cnt_full = (cnt_q >= fci_pkg::CNT_W'(fci_pkg::MAX_POINTS));
  assign cnt_last = cnt_q - fci_pkg::CNT_W'(1);

  // Read address decoder.
  always_comb begin
    unique case (cmd_i.rd_sel)
      fci_pkg::RD_ZERO: raddr = '0;
      fci_pkg::RD_LAST: raddr = cnt_last[fci_pkg::IDX_W-1:0];
      fci_pkg::RD_ONE:  raddr = fci_pkg::IDX_W'(1);
      fci_pkg::RD_NEXT: raddr = idx_q + fci_pkg::IDX_W'(1);
      default:          raddr = '0;
    endcase
  end

  // An append writes only while the table has room.
  assign we = (cmd_i.res_sel == fci_pkg::RES_APPLY) && (act_q == fci_pkg::ACT_APPEND)
              && !cnt_full;

  // Signed magnitude of the product for the unsigned divider.
  assign prod_neg = prod_q[fci_pkg::PROD_W-1];
  assign prod_abs = prod_neg ? fci_pkg::PROD_W'(-prod_q) : fci_pkg::PROD_W'(prod_q);
  assign den_full = fci_pkg::DT_W'(cur_t) - fci_pkg::DT_W'(prev_t_q);

  fci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_abs[fci_pkg::MAG_W-1:0]),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Quotient is truncated toward zero, so its sign follows the product.
  assign div_level = prod_neg
                   ? ({1'b0, prev_s_q} - {1'b0, quotient[fci_pkg::SPEED_W-1:0]})
                   : ({1'b0, prev_s_q} + {1'b0, quotient[fci_pkg::SPEED_W-1:0]});

  // Result register and table count updates.
  always_comb begin
    cnt_d    = cnt_q;
    level_d  = level_q;
    res_st_d = res_st_q;
    unique case (cmd_i.res_sel)
      fci_pkg::RES_NONE: begin
      end
      fci_pkg::RES_APPLY: begin
        level_d = '0;
        if (act_q == fci_pkg::ACT_APPEND) begin
          if (cnt_full) begin
            res_st_d = fci_pkg::ST_FULL;
          end else begin
            res_st_d = fci_pkg::ST_STORED;
            cnt_d    = cnt_q + fci_pkg::CNT_W'(1);
          end
        end else begin
          res_st_d = fci_pkg::ST_CLEARED;
          cnt_d    = '0;
        end
      end
      fci_pkg::RES_EMPTY: begin
        level_d  = '0;
        res_st_d = fci_pkg::ST_EMPTY;
      end
      fci_pkg::RES_RDATA: begin
        level_d  = cur_s;
        res_st_d = fci_pkg::ST_OK;
      end
      fci_pkg::RES_PREV: begin
        level_d  = prev_s_q;
        res_st_d = fci_pkg::ST_OK;
      end
      fci_pkg::RES_NOSEG: begin
        level_d  = '0;
        res_st_d = fci_pkg::ST_NOSEG;
      end
      fci_pkg::RES_DIV: begin
        level_d  = div_level[fci_pkg::SPEED_W-1:0];
        res_st_d = fci_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  // Output word is held until the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= action_i;
      t_q   <= temperature_i;
      sp_q  <= speed_point_i;
    end
    if (cmd_i.load_prev) begin
      prev_t_q <= cur_t;
      prev_s_q <= cur_s;
    end
    if (cmd_i.idx_init) begin
      idx_q <= fci_pkg::IDX_W'(1);
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + fci_pkg::IDX_W'(1);
    end
    if (cmd_i.seg_load) begin
      dt_q  <= fci_pkg::DT_W'(t_q) - fci_pkg::DT_W'(prev_t_q);
      ds_q  <= fci_pkg::DS_W'({1'b0, cur_s}) - fci_pkg::DS_W'({1'b0, prev_s_q});
      den_q <= den_full[fci_pkg::DEN_W-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= fci_pkg::PROD_W'(dt_q) * fci_pkg::PROD_W'(ds_q);
    end
    level_q  <= level_d;
    res_st_q <= res_st_d;
    if (cmd_i.out_load) begin
      duty_q      <= fci_pkg::duty_of(level_q);
      out_level_q <= level_q;
      out_st_q    <= res_st_q;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.is_query   = act_q[fci_pkg::ACT_QUERY_BIT];
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.le_first   = (t_q <= cur_t);
    sts_o.ge_last    = (t_q >= cur_t);
    sts_o.in_seg     = (t_q >= prev_t_q) && (t_q <= cur_t);
    sts_o.zero_width = (cur_t == prev_t_q);
    sts_o.walk_end   = (fci_pkg::CNT_W'(idx_q) == cnt_last);
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign duty_o        = duty_q;
  assign speed_level_o = out_level_q;
  assign status_o      = out_st_q;

endmodule

[rtl/fci_ctrl.sv]
// Controller: sequences clear, append and the query segment walk.
module fci_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fci_pkg::fci_sts_t sts_i,
  output fci_pkg::fci_cmd_t cmd_o
);

  fci_pkg::state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fci_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = fci_pkg::S_APPLY;
        end
      end
      fci_pkg::S_APPLY: begin
        if (sts_i.is_query && !sts_i.cnt_zero) begin
          state_d = fci_pkg::S_FIRST;
        end else begin
          state_d = fci_pkg::S_FINISH;
        end
      end
      fci_pkg::S_FIRST: begin
        state_d = sts_i.le_first ? fci_pkg::S_FINISH : fci_pkg::S_LAST;
      end
      fci_pkg::S_LAST: begin
        state_d = sts_i.ge_last ? fci_pkg::S_FINISH : fci_pkg::S_WALK;
      end
      fci_pkg::S_WALK: begin
        if (sts_i.in_seg) begin
          state_d = sts_i.zero_width ? fci_pkg::S_FINISH : fci_pkg::S_MUL;
        end else if (sts_i.walk_end) begin
          state_d = fci_pkg::S_FINISH;
        end
      end
      fci_pkg::S_MUL:   state_d = fci_pkg::S_DIVGO;
      fci_pkg::S_DIVGO: state_d = fci_pkg::S_DIV;
      fci_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          state_d = fci_pkg::S_FINISH;
        end
      end
      fci_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = fci_pkg::S_IDLE;
        end
      end
      default: state_d = fci_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = fci_pkg::RD_ZERO;
    cmd_o.res_sel = fci_pkg::RES_NONE;
    in_stall_o    = 1'b1;
    unique case (state_q)
      fci_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      fci_pkg::S_APPLY: begin
        if (!sts_i.is_query) begin
          cmd_o.res_sel = fci_pkg::RES_APPLY;
        end else if (sts_i.cnt_zero) begin
          cmd_o.res_sel = fci_pkg::RES_EMPTY;
        end
      end
      fci_pkg::S_FIRST: begin
        cmd_o.load_prev = 1'b1;
        cmd_o.rd_sel    = fci_pkg::RD_LAST;
        if (sts_i.le_first) begin
          cmd_o.res_sel = fci_pkg::RES_RDATA;
        end
      end
      fci_pkg::S_LAST: begin
        cmd_o.idx_init = 1'b1;
        cmd_o.rd_sel   = fci_pkg::RD_ONE;
        if (sts_i.ge_last) begin
          cmd_o.res_sel = fci_pkg::RES_RDATA;
        end
      end
      fci_pkg::S_WALK: begin
        cmd_o.rd_sel = fci_pkg::RD_NEXT;
        if (sts_i.in_seg) begin
          if (sts_i.zero_width) begin
            cmd_o.res_sel = fci_pkg::RES_PREV;
          end else begin
            cmd_o.seg_load = 1'b1;
          end
        end else if (sts_i.walk_end) begin
          cmd_o.res_sel = fci_pkg::RES_NOSEG;
        end else begin
          cmd_o.load_prev = 1'b1;
          cmd_o.idx_inc   = 1'b1;
        end
      end
      fci_pkg::S_MUL:   cmd_o.mul_en    = 1'b1;
      fci_pkg::S_DIVGO: cmd_o.div_start = 1'b1;
      fci_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.res_sel = fci_pkg::RES_DIV;
        end
      end
      fci_pkg::S_FINISH: cmd_o.out_load = sts_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fci_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/fan_curve_interpolator.sv]
// Fan curve interpolator top level: a piecewise-linear temperature-to-duty lookup.
// Each word clears the breakpoint table, appends one breakpoint (up to 32) or
// queries a temperature, and gives exactly one result word. Words are taken one
// at a time; the next word is accepted while a finished result still waits in
// the output register. Clear and append pass through the apply and finish
// states before the next accept. During a query the breakpoints are read one
// per cycle from a single-read-port table in the segment walk, and the
// interpolation quotient comes from a 28-step serial divider. Queries at or
// beyond the end points, and zero-width segments, skip the divider.
module fan_curve_interpolator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fci_pkg::ACTION_W-1:0]      action_i,
  input  logic signed [fci_pkg::TEMP_W-1:0] temperature_i,
  input  logic [fci_pkg::SPEED_W-1:0]       speed_point_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fci_pkg::DUTY_W-1:0]        duty_o,
  output logic [fci_pkg::SPEED_W-1:0]       speed_level_o,
  output logic [fci_pkg::STATUS_W-1:0]      status_o
);

  fci_pkg::fci_cmd_t cmd;
  fci_pkg::fci_sts_t sts;

  // Sequencer.
  fci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, arithmetic and output register.
  fci_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .temperature_i (temperature_i),
    .speed_point_i (speed_point_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .duty_o        (duty_o),
    .speed_level_o (speed_level_o),
    .status_o      (status_o)
  );

endmodule

[rtl/fci_checker.sv]
// Port-level checker for the fan curve interpolator, bound to the top level.
`include "fan_curve_interpolator_macros.svh"

module fci_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [fci_pkg::ACTION_W-1:0]      action_i,
  input logic signed [fci_pkg::TEMP_W-1:0] temperature_i,
  input logic [fci_pkg::SPEED_W-1:0]       speed_point_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [fci_pkg::DUTY_W-1:0]        duty_o,
  input logic [fci_pkg::SPEED_W-1:0]       speed_level_o,
  input logic [fci_pkg::STATUS_W-1:0]      status_o
);

  logic in_acc;
  logic not_ok;
  logic at_full;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign not_ok  = (status_o != fci_pkg::ST_OK);
  assign at_full = (speed_level_o >= fci_pkg::SPEED_W'(fci_pkg::FULL_SPEED));

  // A result word is not withdrawn while the consumer stalls.
  `FCI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // The block works on one word at a time after an accept.
  `FCI_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "second word accepted while busy")

  // Every status but a good query carries a zero speed and duty.
  `FCI_ASSERT_NOW(a_zero_payload, out_valid_o && not_ok, (speed_level_o == '0) && (duty_o == '0), "nonzero level on a non-query status")

  // A speed at or above full scale gives full duty.
  `FCI_ASSERT_NOW(a_full_duty, out_valid_o && at_full, duty_o == fci_pkg::DUTY_W'(fci_pkg::DUTY_MAX), "full speed without full duty")

endmodule

bind fan_curve_interpolator fci_checker u_fci_checker (.*);

[test/tb_top.sv]
// Testbench for the fan curve interpolator: random and directed words checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 7;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 100;
  localparam int PHASE_WORDS    = 260;
  localparam longint TIMEOUT_NS = 64'd1_000_000 * CLK_PERIOD;
  localparam int MAX_REPORTS    = 10;

  // Query codes; only the query bit is decoded, so both act as a query.
  localparam logic [fci_pkg::ACTION_W-1:0] ACT_QUERY    = 2'd2;
  localparam logic [fci_pkg::ACTION_W-1:0] ACT_QUERY_HI = 2'd3;

  typedef struct packed {
    logic [fci_pkg::ACTION_W-1:0] action;
    logic [fci_pkg::TEMP_W-1:0]   temp;
    logic [fci_pkg::SPEED_W-1:0]  speed;
  } fan_word_t;

  typedef struct packed {
    logic [fci_pkg::DUTY_W-1:0]  duty;
    logic [fci_pkg::SPEED_W-1:0] level;
    fci_pkg::status_e            status;
  } duty_result_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_stall_o;
  logic [fci_pkg::ACTION_W-1:0]      action_i      = '0;
  logic signed [fci_pkg::TEMP_W-1:0] temperature_i = '0;
  logic [fci_pkg::SPEED_W-1:0]       speed_point_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i   = 1'b0;
  logic [fci_pkg::DUTY_W-1:0]        duty_o;
  logic [fci_pkg::SPEED_W-1:0]       speed_level_o;
  logic [fci_pkg::STATUS_W-1:0]      status_o;

  // Stimulus and scoreboard storage.
  fan_word_t    pending_words[$];
  duty_result_t expected_duties[$];
  fan_word_t    drive_word;
  logic         in_taken      = 1'b0;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  int           hold_left     = 0;
  logic         hold_start    = 1'b0;
  int           mismatch_count = 0;
  int           words_queued   = 0;

  // Predictor copy of the breakpoint table.
  logic signed [fci_pkg::TEMP_W-1:0] curve_temp[fci_pkg::MAX_POINTS];
  logic [fci_pkg::SPEED_W-1:0]       curve_speed[fci_pkg::MAX_POINTS];
  int                                curve_len = 0;

  fan_curve_interpolator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .temperature_i (temperature_i),
    .speed_point_i (speed_point_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duty_o        (duty_o),
    .speed_level_o (speed_level_o),
    .status_o      (status_o)
  );

  // Free-running clock.
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Works out the result of one accepted word and updates the table copy.
  function automatic duty_result_t predict_fan_duty(fan_word_t w);
    duty_result_t r;
    longint t, t1, t2, s1, s2, lvl, clamped;
    int i;
    bit found;
    r.duty  = '0;
    r.level = '0;
    r.status = fci_pkg::ST_OK;
    if (w.action[fci_pkg::ACT_QUERY_BIT]) begin
      t   = longint'($signed(w.temp));
      lvl = 0;
      if (curve_len == 0) begin
        r.status = fci_pkg::ST_EMPTY;
      end else if (t <= curve_temp[0]) begin
        lvl = curve_speed[0];
      end else if (t >= curve_temp[curve_len-1]) begin
        lvl = curve_speed[curve_len-1];
      end else begin
        // Walk the segments and interpolate inside the first one that holds t.
        found = 1'b0;
        for (i = 0; i + 1 < curve_len && !found; i++) begin
          t1 = curve_temp[i];
          t2 = curve_temp[i+1];
          if (t >= t1 && t <= t2) begin
            found = 1'b1;
            s1 = curve_speed[i];
            s2 = curve_speed[i+1];
            if (t2 == t1) begin
              lvl = s1;
            end else begin
              lvl = s1 + ((t - t1) * (s2 - s1)) / (t2 - t1);
              if (lvl < 0) lvl = 0;
              if (lvl > 4095) lvl = 4095;
            end
          end
        end
        if (!found) r.status = fci_pkg::ST_NOSEG;
      end
      clamped = (lvl > fci_pkg::FULL_SPEED) ? fci_pkg::FULL_SPEED : lvl;
      r.level = lvl[fci_pkg::SPEED_W-1:0];
      r.duty  = fci_pkg::DUTY_W'((clamped * fci_pkg::DUTY_MAX) >> 10);
    end else if (w.action == fci_pkg::ACT_APPEND) begin
      if (curve_len < fci_pkg::MAX_POINTS) begin
        curve_temp[curve_len]  = w.temp;
        curve_speed[curve_len] = w.speed;
        curve_len++;
        r.status = fci_pkg::ST_STORED;
      end else begin
        r.status = fci_pkg::ST_FULL;
      end
    end else begin
      curve_len = 0;
      r.status  = fci_pkg::ST_CLEARED;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic queue_word(logic [fci_pkg::ACTION_W-1:0] action,
                            logic [fci_pkg::TEMP_W-1:0] temp,
                            logic [fci_pkg::SPEED_W-1:0] speed);
    fan_word_t w;
    w.action = action;
    w.temp   = temp;
    w.speed  = speed;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Waits until every queued word has been taken and every result has come back.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_duties.size() != 0)
      @(negedge clk_i);
  endtask

  // One random burst: mostly a fresh curve followed by queries, sometimes noise.
  task automatic queue_random_curve();
    int kind, n, k, q, sel, max_step, cur, step, lo_t, hi_t;
    int temps[$];
    kind = $urandom_range(99);
    if (kind < 12) begin
      // Raw words with any action and any field value.
      repeat ($urandom_range(1, 6))
        queue_word(fci_pkg::ACTION_W'($urandom_range(3)), fci_pkg::TEMP_W'($urandom),
                   fci_pkg::SPEED_W'($urandom));
      return;
    end
    queue_word(fci_pkg::ACT_CLEAR, fci_pkg::TEMP_W'($urandom), fci_pkg::SPEED_W'($urandom));
    // Mostly short curves; now and then one that overflows the table.
    n = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
    max_step = $urandom_range(1) ? 65535 / n : $urandom_range(1, 300);
    cur  = -32768 + int'($urandom_range(0, 65535 - n * max_step));
    lo_t = 32767;
    hi_t = -32768;
    for (k = 0; k < n; k++) begin
      if (kind < 22) begin
        // Broken curve with temperatures in any order.
        cur = int'($urandom_range(65535)) - 32768;
      end else if (k != 0) begin
        step = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(0, max_step));
        cur  = cur + step;
      end
      temps.push_back(cur);
      if (cur < lo_t) lo_t = cur;
      if (cur > hi_t) hi_t = cur;
      queue_word(fci_pkg::ACT_APPEND, fci_pkg::TEMP_W'(cur),
                 fci_pkg::SPEED_W'($urandom_range(4095)));
    end
    q = $urandom_range(2, 10);
    for (k = 0; k < q; k++) begin
      sel = $urandom_range(9);
      if (sel == 0) cur = int'($urandom_range(65535)) - 32768;
      else if (sel == 1) cur = temps[$urandom_range(temps.size() - 1)];
      else if (sel == 2) cur = $urandom_range(1) ? lo_t : hi_t;
      else cur = lo_t + int'($urandom_range(0, hi_t - lo_t));
      queue_word(($urandom_range(7) == 0) ? ACT_QUERY_HI : ACT_QUERY,
                 fci_pkg::TEMP_W'(cur), fci_pkg::SPEED_W'($urandom));
      // An occasional late append extends the curve between queries.
      if ($urandom_range(11) == 0)
        queue_word(fci_pkg::ACT_APPEND, fci_pkg::TEMP_W'($urandom),
                   fci_pkg::SPEED_W'($urandom));
    end
  endtask

  // Sender: offers the next pending word at the falling edge, holding it while stalled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_word    = pending_words.pop_front();
        in_valid_i    <= 1'b1;
        action_i      <= drive_word.action;
        temperature_i <= drive_word.temp;
        speed_point_i <= drive_word.speed;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, forced high during a long hold-off.
  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Hold-off counter.
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result word and records each accepted input word.
  always @(posedge clk_i) begin
    duty_result_t want;
    fan_word_t    seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_duties.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: duty %0d level %0d status %0d",
                                  duty_o, speed_level_o, status_o));
        end else begin
          want = expected_duties.pop_front();
          if (duty_o !== want.duty)
            flag_mismatch($sformatf("duty expected %0d got %0d", want.duty, duty_o));
          if (speed_level_o !== want.level)
            flag_mismatch($sformatf("speed_level expected %0d got %0d",
                                    want.level, speed_level_o));
          if (status_o !== want.status)
            flag_mismatch($sformatf("status expected %0d got %0d", want.status, status_o));
        end
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        seen.action = action_i;
        seen.temp   = temperature_i;
        seen.speed  = speed_point_i;
        expected_duties.push_back(predict_fan_duty(seen));
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    int phase;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: empty table, end points, interpolation both ways, clamping.
    queue_word(ACT_QUERY, 16'sd0, 12'd0);
    queue_word(ACT_QUERY_HI, -16'sd1, 12'hFFF);
    queue_word(fci_pkg::ACT_CLEAR, 16'h0000, 12'd0);
    queue_word(fci_pkg::ACT_APPEND, 16'h8000, 12'd0);
    queue_word(ACT_QUERY, 16'h7FFF, 12'd0);
    queue_word(fci_pkg::ACT_APPEND, -16'sd256, 12'd4095);
    queue_word(fci_pkg::ACT_APPEND, 16'sd0, 12'd512);
    queue_word(fci_pkg::ACT_APPEND, 16'sd0, 12'd1024);
    queue_word(fci_pkg::ACT_APPEND, 16'sd1280, 12'd100);
    queue_word(fci_pkg::ACT_APPEND, 16'h7FFF, 12'd2048);
    queue_word(ACT_QUERY, 16'h8000, 12'd0);
    queue_word(ACT_QUERY, -16'sd1000, 12'd0);
    queue_word(ACT_QUERY, -16'sd128, 12'd0);
    queue_word(ACT_QUERY, 16'sd0, 12'd0);
    queue_word(ACT_QUERY, 16'sd640, 12'd0);
    queue_word(ACT_QUERY, 16'h7FFF, 12'd0);
    queue_word(ACT_QUERY, 16'sd20000, 12'd0);
    queue_word(ACT_QUERY_HI, -16'sd300, 12'hFFF);
    queue_word(fci_pkg::ACT_CLEAR, 16'hFFFF, 12'hFFF);
    queue_word(ACT_QUERY, 16'sd100, 12'd0);
    // A curve that is not ascending, with a repeated point.
    queue_word(fci_pkg::ACT_APPEND, 16'sd500, 12'd300);
    queue_word(fci_pkg::ACT_APPEND, -16'sd500, 12'd900);
    queue_word(fci_pkg::ACT_APPEND, -16'sd500, 12'd700);
    queue_word(fci_pkg::ACT_APPEND, 16'sd200, 12'd1500);
    queue_word(ACT_QUERY, 16'sd0, 12'd0);
    wait_drained();

    // Random phases with different amounts of idling on each side.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      words_queued = 0;
      while (words_queued < PHASE_WORDS) queue_random_curve();
      // The sender pauses here until every result is back.
      wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering words.
    send_idle_pct = 0;
    stall_pct     = 0;
    words_queued  = 0;
    while (words_queued < 12) queue_random_curve();
    @(negedge clk_i);
    hold_start = 1'b1;
    @(negedge clk_i);
    hold_start = 1'b0;
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_duties.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/fci_pkg.sv
rtl/fci_ram.sv
rtl/fci_div.sv
rtl/fci_dp.sv
rtl/fci_ctrl.sv
rtl/fan_curve_interpolator.sv
rtl/fci_checker.sv
test/tb_top.sv
